// ----- src/thermocouple_scratchpad_checker_defines.svh -----
// assertion macros shared by the thermocouple scratchpad checker rtl
`ifndef THERMOCOUPLE_SCRATCHPAD_CHECKER_DEFINES_SVH
`define THERMOCOUPLE_SCRATCHPAD_CHECKER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define TSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tsc_pkg.sv -----
// shared types, constants and the crc-8 function of the scratchpad checker
package tsc_pkg;

  localparam int unsigned DataBytesDef = 8;
  localparam int unsigned PosWidth     = 4;
  localparam logic [7:0]  CrcPoly      = 8'h8C;
  localparam int unsigned OutDataWidth = 24;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } tsc_item_t;

  typedef struct packed {
    logic signed [13:0] temperature_quarter_deg;
    logic               crc_error;
    logic               fault_flag;
    logic               open_circuit;
    logic               short_to_ground;
    logic               short_to_supply;
    logic               reading_ok;
  } tsc_result_t;

  // one-wire crc-8, reflected, one byte lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ data[i];
      crc = {1'b0, crc[7:1]};
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

endpackage

// ----- src/thermocouple_scratchpad_checker.sv -----
// top level of the one-wire thermocouple scratchpad checker
//
//  channel   | dir | tdata (low bit up)                               | tuser
//  ----------+-----+--------------------------------------------------+------------
//  s_axis    | in  | frame_byte[7:0]                                  | frame_start
//  m_axis    | out | temperature_quarter_deg[13:0], crc_error,        | none
//            |     | fault_flag, open_circuit, short_to_ground,       |
//            |     | short_to_supply, reading_ok, zero fill[23:20]    |
//
// one byte request per cycle while the pipe is not stalled: input register, crc
// update and decode, then the result register
// the rate is set by the byte-wide crc-8 step between the two registers
// reset clears the frame position, crc and stored bytes to zero
// a waiting result stalls the pipe only while m_axis_tready is low; the
// input register still takes one byte request during that stall
module thermocouple_scratchpad_checker #(
  parameter int unsigned DATA_BYTES = tsc_pkg::DataBytesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input byte stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // frame_byte[7:0]
  input  logic                                s_axis_tuser,  // frame_start
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // temperature[13:0], crc_error, fault_flag, open_circuit,
  // short_to_ground, short_to_supply, reading_ok, zero fill
  output logic [tsc_pkg::OutDataWidth-1:0]    m_axis_tdata
);
  import tsc_pkg::*;

  `include "thermocouple_scratchpad_checker_defines.svh"

  tsc_item_t   req_item;
  tsc_item_t   item;
  logic        item_valid;
  logic        advance;
  logic        out_free;
  logic        res_valid;
  tsc_result_t res_comb;
  tsc_result_t res_reg;

  assign req_item.frame_byte  = s_axis_tdata;
  assign req_item.frame_start = s_axis_tuser;

  // the held byte moves on once the result register can take a result
  assign advance = item_valid && out_free;

  tsc_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_item_i   (req_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tsc_frame_core #(
    .DATA_BYTES (DATA_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res_comb)
  );

  tsc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_comb),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res_reg),
    .free_o      (out_free)
  );

  // pack the result fields, lowest field in the lowest bits
  assign m_axis_tdata = {4'b0000,
                         res_reg.reading_ok,
                         res_reg.short_to_supply,
                         res_reg.short_to_ground,
                         res_reg.open_circuit,
                         res_reg.fault_flag,
                         res_reg.crc_error,
                         res_reg.temperature_quarter_deg};

  `TSC_ASSERT_NEXT(a_result_from_byte, clk_i, rst_ni, !m_axis_tvalid && !res_valid, !m_axis_tvalid,
                   "result appeared without a crc byte")
  `TSC_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !advance,
                  "byte consumed while result stalled")
  `TSC_ASSERT_NOW(a_ok_consistent, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[19],
                  m_axis_tdata[18:14] == 5'b00000, "reading_ok set with an error flag")

endmodule

// ----- src/tsc_in_stage.sv -----
// input register of the scratchpad checker
module tsc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  tsc_pkg::tsc_item_t req_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output tsc_pkg::tsc_item_t item_o
);
  import tsc_pkg::*;

  logic      valid_q, valid_d;
  tsc_item_t item_q;
  logic      load;

  assign req_ready_o = !valid_q || advance_i;
  assign load        = req_valid_i && req_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= req_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- src/tsc_frame_core.sv -----
// frame state, crc update and result decode of the scratchpad checker
module tsc_frame_core #(
  parameter int unsigned DATA_BYTES = tsc_pkg::DataBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  tsc_pkg::tsc_item_t  item_i,
  output logic                res_valid_o,
  output tsc_pkg::tsc_result_t res_o
);
  import tsc_pkg::*;

  `include "thermocouple_scratchpad_checker_defines.svh"

  localparam logic [PosWidth-1:0] CrcPos = PosWidth'(DATA_BYTES);

  logic [7:0]          crc_q, crc_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          low_q, low_d;
  logic [7:0]          high_q, high_d;
  logic [2:0]          fault_q, fault_d;

  logic [7:0]          crc_eff;
  logic [PosWidth-1:0] pos_eff;
  logic                is_crc;

  // a start marker drops any partial frame
  assign pos_eff = item_i.frame_start ? '0 : pos_q;
  assign crc_eff = item_i.frame_start ? 8'h00 : crc_q;
  assign is_crc  = (pos_eff >= CrcPos);

  always_comb begin
    crc_d   = crc_q;
    pos_d   = pos_q;
    low_d   = low_q;
    high_d  = high_q;
    fault_d = fault_q;
    if (fire_i) begin
      if (is_crc) begin
        crc_d = 8'h00;
        pos_d = '0;
      end else begin
        crc_d = crc8_byte(crc_eff, item_i.frame_byte);
        pos_d = pos_eff + PosWidth'(1);
        if (pos_eff == PosWidth'(0)) begin
          low_d = item_i.frame_byte;
        end else if (pos_eff == PosWidth'(1)) begin
          high_d = item_i.frame_byte;
        end else if (pos_eff == PosWidth'(2)) begin
          fault_d = item_i.frame_byte[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= 8'h00;
      pos_q   <= '0;
      low_q   <= 8'h00;
      high_q  <= 8'h00;
      fault_q <= 3'b000;
    end else begin
      crc_q   <= crc_d;
      pos_q   <= pos_d;
      low_q   <= low_d;
      high_q  <= high_d;
      fault_q <= fault_d;
    end
  end

  always_comb begin
    res_o.temperature_quarter_deg = $signed({high_q, low_q[7:2]});
    res_o.crc_error       = (item_i.frame_byte != crc_eff);
    res_o.fault_flag      = low_q[0];
    res_o.open_circuit    = fault_q[0];
    res_o.short_to_ground = fault_q[1];
    res_o.short_to_supply = fault_q[2];
    res_o.reading_ok      = !(res_o.crc_error || low_q[0] || (|fault_q));
  end

  assign res_valid_o = fire_i && is_crc;

  `TSC_ASSERT_NOW(a_pos_in_range, clk_i, rst_ni, 1'b1, pos_q <= CrcPos, "position past crc byte")
  `TSC_ASSERT_NEXT(a_pos_clear, clk_i, rst_ni, res_valid_o, pos_q == '0 && crc_q == 8'h00,
                   "frame state not cleared after crc byte")
  `TSC_ASSERT_NEXT(a_data_step, clk_i, rst_ni, fire_i && !is_crc,
                   pos_q == $past(pos_eff) + PosWidth'(1),
                   "position did not advance on data byte")

endmodule

// ----- src/tsc_out_stage.sv -----
// result register of the scratchpad checker
module tsc_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tsc_pkg::tsc_result_t res_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output tsc_pkg::tsc_result_t res_o,
  output logic                 free_o
);
  import tsc_pkg::*;

  logic        valid_q, valid_d;
  tsc_result_t res_q;

  assign free_o = !valid_q || res_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- verif/tb_thermocouple_scratchpad_checker.sv -----
// self-checking testbench for the thermocouple scratchpad checker
`timescale 1ns / 100ps

module tb_thermocouple_scratchpad_checker;

  import tsc_pkg::*;

  localparam int unsigned FrameDataBytes = DataBytesDef;
  localparam int unsigned IdlePercent    = 22;
  localparam int unsigned RandomBytes    = 700;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned DrainCycles    = 8;

  // reading of an all-zero frame with a matching crc byte
  localparam tsc_result_t CleanZeroReading = '{
    temperature_quarter_deg: 14'sd0, crc_error: 1'b0, fault_flag: 1'b0,
    open_circuit: 1'b0, short_to_ground: 1'b0, short_to_supply: 1'b0,
    reading_ok: 1'b1
  };
  // same frame, but the crc byte is wrong
  localparam tsc_result_t BadCrcZeroReading = '{
    temperature_quarter_deg: 14'sd0, crc_error: 1'b1, fault_flag: 1'b0,
    open_circuit: 1'b0, short_to_ground: 1'b0, short_to_supply: 1'b0,
    reading_ok: 1'b0
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;  // frame_byte[7:0]
  logic                      s_axis_tuser  = 1'b0;  // frame_start
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // temperature[13:0], crc_error, fault_flag, open_circuit,
  // short_to_ground, short_to_supply, reading_ok, zero fill
  logic [OutDataWidth-1:0]   m_axis_tdata;

  thermocouple_scratchpad_checker #(
    .DATA_BYTES(FrameDataBytes)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // one row of the directed byte sequence
  typedef struct {
    logic [7:0]  data;
    bit          start;
    bit          typed;
    tsc_result_t reading;
  } byte_row_t;

  byte_row_t   directed_rows[$];
  tsc_result_t pending_readings[$];

  // scratchpad decoder state, mirrors the block
  logic [7:0] crc_acc     = '0;
  logic [3:0] frame_pos   = '0;
  logic [7:0] low_byte    = '0;
  logic [7:0] high_byte   = '0;
  logic [2:0] fault_latch = '0;

  bit          calm = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned readings_checked = 0;
  int unsigned crc_errors_seen = 0;
  int unsigned good_readings = 0;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  // one-wire crc-8, lsb first; feedback bit enters at the top, taps at bits 3 and 2
  function automatic logic [7:0] onewire_crc_next(input logic [7:0] c, input logic [7:0] d);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ d[k];
      c  = {fb, c[7:1]} ^ {4'b0000, fb, fb, 2'b00};
    end
    return c;
  endfunction

  // feeds one byte to the decoder state; returns 1 when the crc byte closes a frame
  function automatic bit advance_scratchpad(input logic [7:0] b, input bit st,
                                            output tsc_result_t r);
    r = '0;
    if (st) begin
      frame_pos = '0;
      crc_acc   = '0;
    end
    if (frame_pos < FrameDataBytes) begin
      crc_acc = onewire_crc_next(crc_acc, b);
      case (frame_pos)
        4'd0: low_byte    = b;
        4'd1: high_byte   = b;
        4'd2: fault_latch = b[2:0];
        default: ;
      endcase
      frame_pos = frame_pos + 4'd1;
      return 1'b0;
    end
    r.temperature_quarter_deg = {high_byte, low_byte[7:2]};
    r.crc_error       = (b != crc_acc);
    r.fault_flag      = low_byte[0];
    r.open_circuit    = fault_latch[0];
    r.short_to_ground = fault_latch[1];
    r.short_to_supply = fault_latch[2];
    r.reading_ok      = !(r.crc_error | r.fault_flag | (|fault_latch));
    frame_pos = '0;
    crc_acc   = '0;
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [7:0] data, input bit start,
                                  input bit typed = 1'b0, input tsc_result_t reading = '0);
    byte_row_t row;
    row.data    = data;
    row.start   = start;
    row.typed   = typed;
    row.reading = reading;
    directed_rows.push_back(row);
  endfunction

  // drives one byte request at the falling edge and waits for its acceptance
  task automatic send_request(input logic [7:0] b, input bit st,
                              input bit typed = 1'b0, input tsc_result_t reading = '0);
    tsc_result_t predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    if (advance_scratchpad(b, st, predicted)) begin
      pending_readings.push_back(typed ? reading : predicted);
    end
  endtask

  // sender holds off until every pending reading has come out
  task automatic drain_readings();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
    case ($urandom_range(3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // a complete frame with random content, mostly with a matching crc byte
  task automatic send_frame();
    logic [7:0] b;
    bit         st;
    st = (frame_pos != 0) ? 1'b1 : 1'(($urandom_range(1)));
    // temperature low byte, sometimes an extreme, fault bit often clear
    b = ($urandom_range(7) == 0) ? pick_byte(8'h00, 8'hFC, 8'hFF, 8'h03) : 8'($urandom);
    if ($urandom_range(1) != 0) b[0] = 1'b0;
    send_request(b, st);
    b = ($urandom_range(7) == 0) ? pick_byte(8'h00, 8'h7F, 8'h80, 8'hFF) : 8'($urandom);
    send_request(b, 1'b0);
    // fault bits clear half the time so that good readings are common
    b = 8'($urandom) & (($urandom_range(1) != 0) ? 8'hF8 : 8'hFF);
    send_request(b, 1'b0);
    for (int i = 3; i < FrameDataBytes; i++) send_request(8'($urandom), 1'b0);
    b = ($urandom_range(99) < 85) ? crc_acc : 8'($urandom);
    send_request(b, 1'b0);
  endtask

  // random bytes, random starts: broken and cut frames
  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(12, 1);
    repeat (len) send_request(8'($urandom), ($urandom_range(3) == 0));
  endtask

  function automatic tsc_result_t unpack_reading(input logic [OutDataWidth-1:0] d);
    tsc_result_t r;
    r.temperature_quarter_deg = d[13:0];
    r.crc_error       = d[14];
    r.fault_flag      = d[15];
    r.open_circuit    = d[16];
    r.short_to_ground = d[17];
    r.short_to_supply = d[18];
    r.reading_ok      = d[19];
    return r;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= IdlePercent);
  end

  // result check against the oldest pending reading
  always @(posedge clk_i) begin
    tsc_result_t got;
    tsc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = unpack_reading(m_axis_tdata);
      if (pending_readings.size() == 0) begin
        $error("reading with none pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        compare_field("temperature_quarter_deg", int'(want.temperature_quarter_deg),
                      int'(got.temperature_quarter_deg));
        compare_field("crc_error", want.crc_error, got.crc_error);
        compare_field("fault_flag", want.fault_flag, got.fault_flag);
        compare_field("open_circuit", want.open_circuit, got.open_circuit);
        compare_field("short_to_ground", want.short_to_ground, got.short_to_ground);
        compare_field("short_to_supply", want.short_to_supply, got.short_to_supply);
        compare_field("reading_ok", want.reading_ok, got.reading_ok);
        compare_field("zero fill", 0, int'(m_axis_tdata[OutDataWidth-1:20]));
        readings_checked++;
        if (want.crc_error) crc_errors_seen++;
        if (want.reading_ok) good_readings++;
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // bytes straight after reset, no start marker: all-zero frame, crc matches
    for (int i = 0; i < FrameDataBytes; i++) add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, CleanZeroReading);
    // next frame begins without a start marker, then is cut short
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    // start mid-frame, zero data overwrite the stored bytes, wrong crc byte
    add_row(8'h00, 1'b1);
    for (int i = 1; i < FrameDataBytes; i++) add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b0, 1'b1, BadCrcZeroReading);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].data, directed_rows[i].start,
                   directed_rows[i].typed, directed_rows[i].reading);
    end
    drain_readings();

    while (bytes_sent < RandomBytes + directed_rows.size()) begin
      // a long stretch with no idling on either side
      calm = (bytes_sent >= 300 && bytes_sent < 450);
      if ($urandom_range(29) == 0) drain_readings();
      if ($urandom_range(99) < 75) send_frame();
      else send_noise();
    end
    calm = 1'b0;

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d scratchpad bytes incl. cut frames and restarts", bytes_sent);
    $display("checked %0d readings: %0d with crc error, %0d good",
             readings_checked, crc_errors_seen, good_readings);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
